@@ sv/pbalq_pkg.sv @@
// Shared widths, codes and control types of the port bitmap allocator.
`default_nettype none

package pbalq_pkg;

  localparam int PORT_W = 16;
  localparam int QUOTA_W = 15;
  localparam int CMD_W = 2;
  localparam int STATUS_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_PORT_BASE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_QUOTA = 1'd1;

  localparam logic [PORT_W-1:0] RESET_PORT_BASE = 16'd49152;
  localparam logic [QUOTA_W-1:0] RESET_QUOTA = 15'd16384;

  localparam logic [CMD_W-1:0] CMD_ALLOC_ANY = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC_GIVEN = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_QUOTA = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BUSY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic search_init;
    logic eval_search;
    logic div_init;
    logic div_step;
    logic eval_given;
    logic set_quota;
    logic set_range;
    logic load_out;
    logic clear_wr;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic quota_hit;
    logic in_range;
    logic found;
    logic search_end;
    logic div_last;
    logic clr_last;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ sv/pbalq_if.sv @@
// Request and response channel interfaces of the port bitmap allocator.
`default_nettype none

interface pbalq_req_if;
  logic valid;
  logic ready;
  logic [pbalq_pkg::CMD_W-1:0] command;
  logic [pbalq_pkg::PORT_W-1:0] port_number;

  modport source(output valid, output command, output port_number, input ready);
  modport sink(input valid, input command, input port_number, output ready);
endinterface

interface pbalq_rsp_if;
  logic valid;
  logic ready;
  logic granted;
  logic [pbalq_pkg::PORT_W-1:0] port_out;
  logic [pbalq_pkg::STATUS_W-1:0] status;

  modport source(output valid, output granted, output port_out, output status, input ready);
  modport sink(input valid, input granted, input port_out, input status, output ready);
endinterface

`default_nettype wire

@@ sv/pbalq_ram.sv @@
// Generic simple dual-port RAM with a registered read.
`default_nettype none

module pbalq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ sv/pbalq_ctrl.sv @@
// Controller state machine of the port bitmap allocator.
`default_nettype none

module pbalq_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire pbalq_pkg::dp_stat_t stat,
  output pbalq_pkg::dp_cmd_t       cmd
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DECODE = 4'd2;
  localparam logic [3:0] S_SRD    = 4'd3;
  localparam logic [3:0] S_SEV    = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_GRD    = 4'd6;
  localparam logic [3:0] S_GEV    = 4'd7;
  localparam logic [3:0] S_FIN    = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_valid_next;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd = '0;
    state_next = state;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.command)
          pbalq_pkg::CMD_ALLOC_ANY: begin
            if (stat.quota_hit) begin
              cmd.set_quota = 1'b1;
              state_next = S_FIN;
            end else begin
              cmd.search_init = 1'b1;
              state_next = S_SRD;
            end
          end
          pbalq_pkg::CMD_ALLOC_GIVEN: begin
            if (stat.quota_hit) begin
              cmd.set_quota = 1'b1;
              state_next = S_FIN;
            end else if (!stat.in_range) begin
              cmd.set_range = 1'b1;
              state_next = S_FIN;
            end else begin
              cmd.div_init = 1'b1;
              state_next = S_DIV;
            end
          end
          pbalq_pkg::CMD_FREE: begin
            if (!stat.in_range) begin
              cmd.set_range = 1'b1;
              state_next = S_FIN;
            end else begin
              cmd.div_init = 1'b1;
              state_next = S_DIV;
            end
          end
          default: begin
            cmd.set_range = 1'b1;
            state_next = S_FIN;
          end
        endcase
      end
      S_SRD: begin
        state_next = S_SEV;
      end
      S_SEV: begin
        cmd.eval_search = 1'b1;
        if (stat.found || stat.search_end) begin
          state_next = S_FIN;
        end else begin
          state_next = S_SRD;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_GRD;
        end
      end
      S_GRD: begin
        state_next = S_GEV;
      end
      S_GEV: begin
        cmd.eval_given = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          out_valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/pbalq_dp.sv @@
// Datapath of the port bitmap allocator: bitmap RAM, search, offset split, counters.
`default_nettype none

module pbalq_dp #(
  parameter int NUM_PORTS = 16384,
  parameter int WORD_BITS = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [pbalq_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [pbalq_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic [pbalq_pkg::CMD_W-1:0]         in_command,
  input  wire logic [pbalq_pkg::PORT_W-1:0]        in_port,
  input  wire pbalq_pkg::dp_cmd_t                  cmd,
  output pbalq_pkg::dp_stat_t                      stat,
  output logic                                     out_granted,
  output logic [pbalq_pkg::PORT_W-1:0]             out_port,
  output logic [pbalq_pkg::STATUS_W-1:0]           out_status
);

  localparam int NUM_WORDS = (NUM_PORTS + WORD_BITS - 1) / WORD_BITS;
  localparam int WAW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BW = $clog2(WORD_BITS);
  localparam int BW1 = $clog2(WORD_BITS + 1);
  localparam int CNTW = $clog2(NUM_PORTS + 1);
  localparam int MW = (CNTW > BW1) ? CNTW : BW1;
  localparam int QW = (CNTW > pbalq_pkg::QUOTA_W) ? CNTW : pbalq_pkg::QUOTA_W;
  localparam int RW = pbalq_pkg::PORT_W + 1;
  localparam int OW = pbalq_pkg::PORT_W;
  localparam int LAST_WORD = NUM_WORDS - 1;
  localparam int LAST_BITS = NUM_PORTS - (NUM_WORDS - 1) * WORD_BITS;
  // Rounded-up reciprocal of the word width; the quotient it gives is exact
  // for every offset of PORT_W bits.
  localparam int RS = OW + BW;
  localparam int RM = ((1 << RS) + WORD_BITS - 1) / WORD_BITS;
  localparam int PW = 2 * OW + 1;

  // Configuration registers.
  logic [pbalq_pkg::PORT_W-1:0]  range_base;
  logic [pbalq_pkg::QUOTA_W-1:0] quota;

  // Item registers.
  logic [pbalq_pkg::CMD_W-1:0]  cmd_r;
  logic [pbalq_pkg::PORT_W-1:0] port_r;

  // Allocator state.
  logic [WAW-1:0]  cur_word;
  logic [BW-1:0]   cur_bit;
  logic [CNTW-1:0] used_count;
  logic [CNTW-1:0] remaining;
  logic [WAW-1:0]  clr_cnt;

  // Offset split into word and bit by a reciprocal multiplication.
  logic [OW-1:0]  rem;
  logic [WAW-1:0] qt;
  logic           k;

  // Result being built.
  logic                            res_granted;
  logic [pbalq_pkg::PORT_W-1:0]    res_port;
  logic [pbalq_pkg::STATUS_W-1:0]  res_status;

  logic [WORD_BITS-1:0] rd_data;
  logic [WORD_BITS-1:0] wr_data;
  logic [WAW-1:0]       rd_addr;
  logic [WAW-1:0]       wr_addr;
  logic                 wr_en;

  logic [pbalq_pkg::PORT_W-1:0] off;
  logic                         in_range;
  logic                         quota_hit;
  logic                         last_word;
  logic [BW1-1:0]               lim;
  logic [WORD_BITS-1:0]         cand;
  logic                         found;
  logic [BW-1:0]                f;
  logic [BW1-1:0]               span_full;
  logic [BW1-1:0]               span;
  logic                         search_end;
  logic [BW1-1:0]               adv;
  logic [BW1-1:0]               nb;
  logic                         wrap;
  logic [WAW-1:0]               next_word;
  logic [RW-1:0]                grant_pos;
  logic [pbalq_pkg::PORT_W-1:0] grant_port;
  logic [PW-1:0]                prod;
  logic [BW-1:0]                gbit;
  logic [WORD_BITS-1:0]         gmask;
  logic [WORD_BITS-1:0]         fmask;
  logic                         given_ok;
  logic                         is_given;

  assign off = port_r - range_base;
  assign in_range = (port_r >= range_base) && (RW'(off) < RW'(NUM_PORTS));
  assign quota_hit = (QW'(used_count) >= QW'(quota)) || (used_count >= CNTW'(NUM_PORTS));

  assign last_word = (cur_word == WAW'(LAST_WORD));
  assign lim = last_word ? BW1'(LAST_BITS) : BW1'(WORD_BITS);

  // Free bits of the current word from the probe position on, inside the range
  // and inside the probes still left.
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      cand[i] = !rd_data[i] && (BW1'(i) >= BW1'(cur_bit)) && (BW1'(i) < lim)
                && (MW'(BW1'(i) - BW1'(cur_bit)) < MW'(remaining));
    end
  end

  assign found = |cand;

  always_comb begin
    f = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        f = BW'(i);
      end
    end
  end

  assign span_full = lim - BW1'(cur_bit);
  assign search_end = (MW'(remaining) <= MW'(span_full));
  assign span = search_end ? BW1'(remaining) : span_full;
  assign adv = found ? (BW1'(f) - BW1'(cur_bit) + BW1'(1)) : span;
  assign nb = BW1'(cur_bit) + adv;
  assign wrap = (nb == lim);
  assign next_word = last_word ? '0 : cur_word + WAW'(1);

  assign grant_pos = RW'(cur_word) * RW'(WORD_BITS) + RW'(f);
  assign grant_port = grant_pos[pbalq_pkg::PORT_W-1:0] + range_base;

  assign prod = PW'(rem) * PW'(RM);

  assign is_given = (cmd_r == pbalq_pkg::CMD_ALLOC_GIVEN);
  assign gbit = rem[BW-1:0];
  assign gmask = WORD_BITS'(1) << gbit;
  assign fmask = WORD_BITS'(1) << f;
  assign given_ok = is_given ? !rd_data[gbit] : rd_data[gbit];

  assign rd_addr = (cmd_r == pbalq_pkg::CMD_ALLOC_ANY) ? cur_word : qt;
  assign wr_addr = cmd.clear_wr ? clr_cnt : rd_addr;
  assign wr_en = cmd.clear_wr || (cmd.eval_search && found) || (cmd.eval_given && given_ok);

  always_comb begin
    if (cmd.clear_wr) begin
      wr_data = '0;
    end else if (cmd.eval_search) begin
      wr_data = rd_data | fmask;
    end else if (is_given) begin
      wr_data = rd_data | gmask;
    end else begin
      wr_data = rd_data & ~gmask;
    end
  end

  pbalq_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(NUM_WORDS)
  ) u_bitmap (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  assign stat.command = cmd_r;
  assign stat.quota_hit = quota_hit;
  assign stat.in_range = in_range;
  assign stat.found = found;
  assign stat.search_end = search_end;
  assign stat.div_last = (k == 1'b0);
  assign stat.clr_last = (clr_cnt == WAW'(LAST_WORD));

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      range_base <= pbalq_pkg::RESET_PORT_BASE;
      quota <= pbalq_pkg::RESET_QUOTA;
      cur_word <= '0;
      cur_bit <= '0;
      used_count <= '0;
      remaining <= '0;
      clr_cnt <= '0;
    end else begin
      if (cfg_write && (cfg_index == pbalq_pkg::REG_PORT_BASE)) begin
        range_base <= cfg_data;
      end
      if (cfg_write && (cfg_index == pbalq_pkg::REG_QUOTA)) begin
        quota <= cfg_data[pbalq_pkg::QUOTA_W-1:0];
      end
      if (cmd.clear_wr) begin
        clr_cnt <= clr_cnt + WAW'(1);
      end
      if (cmd.search_init) begin
        remaining <= CNTW'(NUM_PORTS);
      end
      if (cmd.eval_search) begin
        remaining <= remaining - CNTW'(span);
        if (wrap) begin
          cur_bit <= '0;
          cur_word <= next_word;
        end else begin
          cur_bit <= nb[BW-1:0];
        end
        if (found) begin
          used_count <= used_count + CNTW'(1);
        end
      end
      if (cmd.eval_given && given_ok) begin
        if (is_given) begin
          used_count <= used_count + CNTW'(1);
        end else if (used_count != '0) begin
          used_count <= used_count - CNTW'(1);
        end
      end
    end
  end

  // Payload registers. The first split step takes the word index from the
  // reciprocal product, the second leaves the bit index in rem.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      cmd_r <= in_command;
      port_r <= in_port;
    end
    if (cmd.div_init) begin
      rem <= off;
      qt <= '0;
      k <= 1'b1;
    end
    if (cmd.div_step) begin
      if (k) begin
        qt <= WAW'(prod >> RS);
      end else begin
        rem <= rem - OW'(qt) * OW'(WORD_BITS);
      end
      k <= 1'b0;
    end
    if (cmd.set_quota) begin
      res_granted <= 1'b0;
      res_status <= pbalq_pkg::ST_QUOTA;
      res_port <= port_r;
    end
    if (cmd.set_range) begin
      res_granted <= 1'b0;
      res_status <= pbalq_pkg::ST_RANGE;
      res_port <= port_r;
    end
    if (cmd.eval_search) begin
      res_granted <= found;
      res_status <= found ? pbalq_pkg::ST_OK : pbalq_pkg::ST_BUSY;
      res_port <= found ? grant_port : port_r;
    end
    if (cmd.eval_given) begin
      res_granted <= given_ok;
      res_status <= given_ok ? pbalq_pkg::ST_OK : pbalq_pkg::ST_BUSY;
      res_port <= port_r;
    end
    if (cmd.load_out) begin
      out_granted <= res_granted;
      out_port <= res_port;
      out_status <= res_status;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    used_count <= CNTW'(NUM_PORTS))
    else $error("used count exceeds the port count");

  a_probe_in_word: assert property (@(posedge clk) disable iff (rst)
    BW1'(cur_bit) < lim)
    else $error("probe position lies outside its word");

  a_search_budget: assert property (@(posedge clk) disable iff (rst)
    cmd.eval_search |-> (remaining != '0))
    else $error("search step taken with no probes left");

endmodule

`default_nettype wire

@@ sv/port_bitmap_allocator_with_quota.sv @@
// Top level of the next-fit port bitmap allocator with a quota.
`default_nettype none

// Allocates dynamic port numbers from a bitmap of NUM_PORTS bits held in a RAM
// of WORD_BITS-wide words. After reset the block runs a clearing pass that
// writes one word per cycle over all NUM_WORDS words (512 at the defaults),
// during which no request is taken; configuration writes are accepted at any
// time the block is idle. Requests are handled one at a time. Allocate-any
// passes through a decode state and a result state, and its next-fit search
// spends a RAM read state and an evaluation state on every bitmap word that it
// visits. Allocate-given and free first split the port offset into word and
// bit with a multiplication by the reciprocal of the word width, in a word
// step and a bit step, and then read the word in a read state and an
// evaluation state. Refusals for quota or range go from the decode state
// straight to the result state. The finished result sits in an output
// register, so the next request is taken while a result still waits for its
// transfer.
module port_bitmap_allocator_with_quota #(
  parameter int NUM_PORTS = 16384,
  parameter int WORD_BITS = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  pbalq_req_if.sink                              in_ch,
  pbalq_rsp_if.source                            out_ch,
  input  wire logic                              cfg_write,
  input  wire logic [pbalq_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [pbalq_pkg::CFG_DATA_W-1:0]  cfg_data
);

  pbalq_pkg::dp_cmd_t  cmd;
  pbalq_pkg::dp_stat_t stat;
  logic                in_ready;
  logic                out_valid;

  // The controller sequences each request; the datapath holds the bitmap,
  // the rotating search offset, the used count and the result registers.
  pbalq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pbalq_dp #(
    .NUM_PORTS(NUM_PORTS),
    .WORD_BITS(WORD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_command (in_ch.command),
    .in_port    (in_ch.port_number),
    .cmd        (cmd),
    .stat       (stat),
    .out_granted(out_ch.granted),
    .out_port   (out_ch.port_out),
    .out_status (out_ch.status)
  );

  assign in_ch.ready = in_ready;
  assign out_ch.valid = out_valid;

endmodule

`default_nettype wire

@@ verif/pbalq_result_check.sv @@
// Result checker of the port bitmap allocator: predicts each response and compares it.
`timescale 1ns / 100ps

module pbalq_result_check #(
  parameter int NUM_PORTS = 16384
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  pbalq_req_if                                   req,
  pbalq_rsp_if                                   rsp,
  input  wire logic                              cfg_write,
  input  wire logic [pbalq_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [pbalq_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                                     mismatches,
  output int                                     results_due,
  output int                                     results_seen,
  output int                                     grants_seen
);
  import pbalq_pkg::*;

  typedef struct packed {
    logic                granted;
    logic [PORT_W-1:0]   port_out;
    logic [STATUS_W-1:0] status;
  } port_result_t;

  port_result_t       awaited_results[$];
  bit                 port_held[NUM_PORTS];
  int unsigned        probe_next;
  int unsigned        held_count;
  logic [PORT_W-1:0]  range_base;
  logic [QUOTA_W-1:0] quota_limit;

  // Works out the response to one request and updates the mirrored allocator state.
  function automatic port_result_t next_port_result(input logic [CMD_W-1:0] cmd,
                                                    input logic [PORT_W-1:0] port);
    port_result_t r;
    int unsigned  cap;
    int unsigned  off;
    int unsigned  probe;
    bit           at_quota;
    bit           in_range;
    r.granted  = 1'b0;
    r.status   = ST_RANGE;
    r.port_out = port;
    cap = (quota_limit > NUM_PORTS) ? NUM_PORTS : quota_limit;
    at_quota = held_count >= cap;
    off = 32'(port) - 32'(range_base);
    in_range = (port >= range_base) && (off < NUM_PORTS);
    case (cmd)
      CMD_ALLOC_ANY: begin
        if (at_quota) begin
          r.status = ST_QUOTA;
        end else begin
          r.status = ST_BUSY;
          for (int i = 0; i < NUM_PORTS; i++) begin
            probe = probe_next;
            probe_next = (probe_next + 1) % NUM_PORTS;
            if (!port_held[probe]) begin
              port_held[probe] = 1'b1;
              held_count++;
              r.granted  = 1'b1;
              r.status   = ST_OK;
              r.port_out = PORT_W'(probe + range_base);
              break;
            end
          end
        end
      end
      CMD_ALLOC_GIVEN: begin
        if (at_quota) begin
          r.status = ST_QUOTA;
        end else if (!in_range) begin
          r.status = ST_RANGE;
        end else if (port_held[off]) begin
          r.status = ST_BUSY;
        end else begin
          port_held[off] = 1'b1;
          held_count++;
          r.granted = 1'b1;
          r.status  = ST_OK;
        end
      end
      CMD_FREE: begin
        if (!in_range) begin
          r.status = ST_RANGE;
        end else if (!port_held[off]) begin
          r.status = ST_BUSY;
        end else begin
          port_held[off] = 1'b0;
          if (held_count != 0) held_count--;
          r.granted = 1'b1;
          r.status  = ST_OK;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report(input string field, input int unsigned want, input int unsigned got);
    $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin
    port_result_t want;
    if (rst) begin
      awaited_results.delete();
      port_held   = '{default: 1'b0};
      probe_next  = 0;
      held_count  = 0;
      range_base  = RESET_PORT_BASE;
      quota_limit = RESET_QUOTA;
    end else begin
      // Responses are taken before requests so that a request accepted at this
      // edge can never be matched against a response already on the bus.
      if (rsp.valid && rsp.ready) begin
        results_seen++;
        if (rsp.granted) grants_seen++;
        if (awaited_results.size() == 0) begin
          $display("%0t ns: response with none expected, granted %0d port %0d status %0d",
                   $time, rsp.granted, rsp.port_out, rsp.status);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          if (rsp.granted !== want.granted) report("granted", want.granted, rsp.granted);
          if (rsp.port_out !== want.port_out) report("port_out", want.port_out, rsp.port_out);
          if (rsp.status !== want.status) report("status", want.status, rsp.status);
        end
      end
      if (req.valid && req.ready) begin
        awaited_results.push_back(next_port_result(req.command, req.port_number));
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_PORT_BASE: range_base = cfg_data;
          REG_QUOTA:     quota_limit = cfg_data[QUOTA_W-1:0];
          default: ;
        endcase
      end
    end
    results_due = awaited_results.size();
  end

endmodule

@@ verif/port_bitmap_allocator_with_quota_tb.sv @@
// Testbench top of the port bitmap allocator: stimulus, register settings and verdict.
`timescale 1ns / 100ps

module port_bitmap_allocator_with_quota_tb;
  import pbalq_pkg::*;

  localparam int NUM_PORTS = 16384;
  localparam int WORD_BITS = 32;
  // The longest quiet stretch of a correct run is the clearing pass after
  // reset or a next-fit search over many held words.
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 32;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // When set, neither the request side nor the response side idles at random.
  bit                     steady;
  // Stimulus copy of the range base register, so that random ports land near the range.
  logic [PORT_W-1:0]      base_port;
  int                     requests_sent;
  int                     register_writes;
  int                     idle_cycles;

  int mismatches;
  int results_due;
  int results_seen;
  int grants_seen;

  pbalq_req_if req_ch();
  pbalq_rsp_if rsp_ch();

  port_bitmap_allocator_with_quota #(
    .NUM_PORTS(NUM_PORTS),
    .WORD_BITS(WORD_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_ch(req_ch),
    .out_ch(rsp_ch),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  pbalq_result_check #(
    .NUM_PORTS(NUM_PORTS)
  ) result_check (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .mismatches(mismatches),
    .results_due(results_due),
    .results_seen(results_seen),
    .grants_seen(grants_seen)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // The response side stalls at random about 29 percent of the time, except in a
  // steady stretch.
  always @(negedge clk) begin
    rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 29);
  end

  // Watchdog: any transfer on either channel restarts the count of quiet cycles.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles, giving up", $time, idle_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Presents one request and holds it until the transfer. The task starts and
  // ends at a falling edge; valid is left high so that back-to-back requests
  // never see it dropped and raised in the same time step.
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [PORT_W-1:0] port);
    while (!steady && $urandom_range(0, 99) < 29) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.command     <= cmd;
    req_ch.port_number <= port;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
    requests_sent++;
  endtask

  // Stops sending and waits until every predicted response has had its transfer.
  // Since every request gives exactly one response, the block is idle then.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    do @(negedge clk); while (results_due != 0);
  endtask

  // Writes one register; only called while the block is idle.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    if (idx == REG_PORT_BASE) base_port = value;
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
    register_writes++;
  endtask

  initial begin
    int unsigned       pick;
    logic [CMD_W-1:0]  cmd;
    logic [PORT_W-1:0] port;

    rst                = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.command     = CMD_ALLOC_ANY;
    req_ch.port_number = '0;
    cfg_write          = 1'b0;
    cfg_index          = REG_PORT_BASE;
    cfg_data           = '0;
    steady             = 1'b0;
    base_port          = RESET_PORT_BASE;
    requests_sent      = 0;
    register_writes    = 0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Directed part under the reset settings: range base 49152, full quota.
    // The first request also waits out the clearing pass of the bitmap.
    send_request(CMD_ALLOC_ANY, 16'h0000);             // lowest offset of the range
    send_request(CMD_ALLOC_ANY, 16'hFFFF);             // next offset
    send_request(CMD_ALLOC_GIVEN, 16'd49152);          // already held
    send_request(CMD_ALLOC_GIVEN, 16'd65535);          // top of the range
    send_request(CMD_ALLOC_GIVEN, 16'd49151);          // just below the range
    send_request(CMD_ALLOC_GIVEN, 16'd0);              // far below the range
    send_request(CMD_FREE, 16'd49153);                 // release a held port
    send_request(CMD_FREE, 16'd49153);                 // release it again: not held
    send_request(CMD_FREE, 16'd65535);
    send_request(CMD_FREE, 16'd0);                     // out of range
    send_request(CMD_UNUSED, 16'hFFFF);                // unused command code
    send_request(CMD_UNUSED, 16'h0000);
    send_request(CMD_ALLOC_GIVEN, 16'd49154);
    send_request(CMD_ALLOC_ANY, 16'h1234);             // next-fit skips the held offset

    // Quota set at the number of ports held: the quota refusal comes before
    // the range check, and freeing is never refused for quota.
    drain_results();
    write_reg(REG_QUOTA, 16'd3);
    send_request(CMD_ALLOC_ANY, 16'hA5A5);
    send_request(CMD_ALLOC_GIVEN, 16'd0);
    send_request(CMD_FREE, 16'd49152);
    send_request(CMD_ALLOC_ANY, 16'h5A5A);
    send_request(CMD_ALLOC_ANY, 16'h0F0F);

    // A quota of zero refuses every allocation.
    drain_results();
    write_reg(REG_QUOTA, 16'd0);
    send_request(CMD_ALLOC_GIVEN, 16'd49160);
    send_request(CMD_FREE, 16'd49154);

    // Range at the bottom of the port space, quota above the port count.
    drain_results();
    write_reg(REG_PORT_BASE, 16'd0);
    write_reg(REG_QUOTA, 16'h7FFF);
    send_request(CMD_ALLOC_GIVEN, 16'd16383);
    send_request(CMD_ALLOC_GIVEN, 16'd16384);
    send_request(CMD_FREE, 16'd0);
    send_request(CMD_ALLOC_ANY, 16'h0000);

    // Range base at the very top, so granted ports wrap past 65535.
    drain_results();
    write_reg(REG_PORT_BASE, 16'd65535);
    send_request(CMD_ALLOC_GIVEN, 16'd65535);
    send_request(CMD_FREE, 16'd65534);
    send_request(CMD_ALLOC_ANY, 16'hFFFF);

    // Random part: six settings of 100 requests each. Most ports fall in a
    // small window of the range where next-fit grants cluster, so claims and
    // releases often meet held ports; the rest sit on the range edges or are
    // fully random. Small quotas keep the quota refusal busy.
    for (int s = 0; s < 6; s++) begin
      drain_results();
      case (s)
        0: begin
          write_reg(REG_PORT_BASE, 16'd49152);
          write_reg(REG_QUOTA, 16'd16384);
        end
        1: begin
          write_reg(REG_PORT_BASE, 16'd1000);
          write_reg(REG_QUOTA, 16'd24);
        end
        2: begin
          write_reg(REG_PORT_BASE, 16'd0);
          write_reg(REG_QUOTA, 16'h7FFF);
        end
        3: begin
          write_reg(REG_PORT_BASE, 16'd20000);
          write_reg(REG_QUOTA, 16'd6);
        end
        4: begin
          write_reg(REG_PORT_BASE, 16'd49152);
          write_reg(REG_QUOTA, 16'd300);
        end
        default: begin
          write_reg(REG_PORT_BASE, 16'd65535);
          write_reg(REG_QUOTA, 16'd16384);
        end
      endcase
      // The third setting runs with no random idling on either side.
      steady = (s == 2);
      for (int n = 0; n < 100; n++) begin
        // Now and then the sender holds off until every response is back.
        if ($urandom_range(0, 99) < 2) drain_results();
        pick = $urandom_range(0, 99);
        if (pick < 45) cmd = CMD_ALLOC_ANY;
        else if (pick < 70) cmd = CMD_ALLOC_GIVEN;
        else if (pick < 96) cmd = CMD_FREE;
        else cmd = CMD_UNUSED;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          port = base_port + PORT_W'($urandom_range(0, 511));
        end else if (pick < 85) begin
          case ($urandom_range(0, 3))
            0:       port = base_port;
            1:       port = base_port - 1'b1;
            2:       port = base_port + PORT_W'(NUM_PORTS - 1);
            default: port = base_port + PORT_W'(NUM_PORTS);
          endcase
        end else begin
          port = PORT_W'($urandom);
        end
        send_request(cmd, port);
      end
    end
    steady = 1'b0;

    drain_results();
    // A few more cycles catch any response that should not exist.
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Sent %0d requests across %0d register writes, covering quota, range and",
             requests_sent, register_writes);
    $display("wrap-around settings; %0d responses checked, %0d of them grants.",
             results_seen, grants_seen);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/pbalq_pkg.sv
sv/pbalq_if.sv
sv/pbalq_ram.sv
sv/pbalq_ctrl.sv
sv/pbalq_dp.sv
sv/port_bitmap_allocator_with_quota.sv
verif/pbalq_result_check.sv
verif/port_bitmap_allocator_with_quota_tb.sv
